// ----- rtl/bdl_pkg.sv -----
`default_nettype none
package bdl_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_W         = 4;
	localparam int ENABLE_W       = 16;
	localparam int DEBOUNCE_W     = 8;
	localparam int LONGPRESS_W    = 12;
	localparam int DWELL_W        = 14;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEB_LIMIT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT  = 2'd2;

	localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET  = 8'd3;
	localparam logic [LONGPRESS_W-1:0] LONGPRESS_RESET = 12'd100;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_LONG    = 2'd2
	} bdl_event_t;

	typedef struct packed {
		logic [ENABLE_W-1:0]    slot_enable;
		logic [DEBOUNCE_W-1:0]  deb_limit;
		logic [LONGPRESS_W-1:0] long_limit;
	} bdl_cfg_t;

	typedef struct packed {
		logic       emit;
		bdl_event_t kind;
	} bdl_evt_t;

endpackage
`default_nettype wire

// ----- rtl/bdl_cfg.sv -----
`default_nettype none
module bdl_cfg
	import bdl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output bdl_cfg_t                    cfg,
	output logic [ENABLE_W-1:0]         slot_clear
);

	bdl_cfg_t cfg_q;

	assign cfg = cfg_q;

	// slots turning from disabled to enabled restart
	assign slot_clear = (cfg_we && cfg_index == REG_SLOT_ENABLE) ?
		(cfg_data[ENABLE_W-1:0] & ~cfg_q.slot_enable) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_enable <= '0;
			cfg_q.deb_limit   <= DEBOUNCE_RESET;
			cfg_q.long_limit  <= LONGPRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_ENABLE: cfg_q.slot_enable <= cfg_data[ENABLE_W-1:0];
				REG_DEB_LIMIT:   cfg_q.deb_limit   <= cfg_data[DEBOUNCE_W-1:0];
				REG_LONG_LIMIT:  cfg_q.long_limit  <= cfg_data[LONGPRESS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bdl_slots.sv -----
`default_nettype none
module bdl_slots
	import bdl_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bdl_cfg_t          cfg,
	input  wire logic [ENABLE_W-1:0] slot_clear,
	input  wire logic              advance,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic              level,
	output bdl_evt_t               evt
);

	localparam int DEPTH = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                      stable_q [DEPTH];
	logic signed [DWELL_W-1:0] dwell_q  [DEPTH];

	logic                      in_range;
	logic                      active;
	logic [IW-1:0]             idx;
	logic                      st;
	logic signed [DWELL_W-1:0] d;
	logic signed [DWELL_W-1:0] dp;
	logic signed [DWELL_W-1:0] dn;
	logic signed [DWELL_W-1:0] deb;
	logic signed [DWELL_W-1:0] lp_neg;
	logic                      new_st;
	logic signed [DWELL_W-1:0] new_d;

	assign in_range = 32'(slot) < SLOT_COUNT;
	assign active   = in_range && cfg.slot_enable[slot];
	assign idx      = in_range ? slot[IW-1:0] : '0;
	assign st       = stable_q[idx];
	assign d        = dwell_q[idx];
	assign deb      = $signed({{(DWELL_W-DEBOUNCE_W){1'b0}}, cfg.deb_limit});
	assign lp_neg   = -$signed({{(DWELL_W-LONGPRESS_W){1'b0}}, cfg.long_limit});
	assign dp       = (d < 0) ? '0 : d;
	assign dn       = (d > 0) ? '0 : d;

	always_comb begin
		evt.emit = 1'b0;
		evt.kind = EV_PRESS;
		new_st   = st;
		new_d    = '0;
		if (level != st) begin
			if (dp > deb) begin
				evt.emit = active;
				evt.kind = level ? EV_RELEASE : EV_PRESS;
				new_st   = level;
			end else begin
				new_d = dp + DWELL_W'(1);
			end
		end else if (!st) begin
			if (dn < lp_neg) begin
				evt.emit = active;
				evt.kind = EV_LONG;
			end else begin
				new_d = dn - DWELL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				stable_q[i] <= 1'b1;
				dwell_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (slot_clear[i]) begin
					stable_q[i] <= 1'b1;
					dwell_q[i]  <= '0;
				end else if (advance && active && idx == IW'(i)) begin
					stable_q[i] <= new_st;
					dwell_q[i]  <= new_d;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/button_debounce_longpress_top.sv -----
`default_nettype none
// A word taken into the input register gives its event through the output register on m_tvalid.
// Throughput: one sample per cycle; s_tready drops only while an event waits on m_tready
// and the sample in the input register would give another one.
// Per-slot state is in flip-flops, read and written within the one pass.
// Reset (arst_n, asynchronous): all slots released with zero count, no slot enabled,
// debounce 3, long press 100, both registers empty.
module button_debounce_longpress_top
	import bdl_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,  // slot[3:0], level[4], zero[7:5]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata   // button_slot[3:0], event_kind[5:4], zero[7:6]
);

	bdl_cfg_t            cfg;
	logic [ENABLE_W-1:0] slot_clear;
	bdl_evt_t            evt;

	logic              valid_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              level_s1;
	logic              advance;
	logic              valid_s2;
	logic [SLOT_W-1:0] slot_s2;
	bdl_event_t        kind_s2;

	bdl_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.slot_clear (slot_clear)
	);

	bdl_slots #(.SLOT_COUNT(SLOT_COUNT)) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.slot_clear (slot_clear),
		.advance    (advance),
		.slot       (slot_s1),
		.level      (level_s1),
		.evt        (evt)
	);

	assign advance  = valid_s1 && (!evt.emit || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, kind_s2, slot_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			slot_s1  <= s_tdata[3:0];
			level_s1 <= s_tdata[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && evt.emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.emit) begin
			slot_s2 <= slot_s1;
			kind_s2 <= evt.kind;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && evt.emit && valid_s2 && !m_tready))
		else $error("input stalled without a pending event");

	a_emit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && evt.emit) |-> cfg.slot_enable[slot_s1])
		else $error("event from a disabled slot");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind_s2 == EV_PRESS || kind_s2 == EV_RELEASE || kind_s2 == EV_LONG))
		else $error("illegal event kind");

	a_load_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && evt.emit) |=> (m_tvalid && m_tdata[3:0] == $past(slot_s1)))
		else $error("event not captured");

endmodule
`default_nettype wire

// ----- test/tb_button_debounce_longpress_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_button_debounce_longpress_top;
	import bdl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BP_HOLD_CYCLES = 300;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		bdl_event_t        kind;
	} button_event_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [7:0]             m_tdata;

	button_debounce_longpress_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [ENABLE_W-1:0]       en_mask;
	logic [DEBOUNCE_W-1:0]     deb_ticks;
	logic [LONGPRESS_W-1:0]    long_ticks;
	logic                      stable_lvl [SLOT_COUNT_DEF];
	logic signed [DWELL_W-1:0] dwell      [SLOT_COUNT_DEF];

	button_event_t event_q[$];
	button_event_t got_ev;
	int mismatch_count = 0;
	int events_checked = 0;
	int live_words     = 0;
	int quiet_cycles   = 0;
	int hold_left      = 0;
	int rdy_gap        = 0;
	bit src_idle       = 1'b1;
	bit rdy_idle       = 1'b1;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic bit debounce_predict(input logic [SLOT_W-1:0] s, input logic lvl,
			output bdl_event_t kind);
		logic signed [DWELL_W-1:0] d;
		kind = EV_PRESS;
		if (!en_mask[s])
			return 1'b0;
		d = dwell[s];
		if (lvl != stable_lvl[s]) begin
			if (d < 0)
				d = '0;
			if (d > $signed({6'd0, deb_ticks})) begin
				stable_lvl[s] = lvl;
				dwell[s] = '0;
				kind = lvl ? EV_RELEASE : EV_PRESS;
				return 1'b1;
			end
			dwell[s] = d + 14'sd1;
			return 1'b0;
		end
		if (!stable_lvl[s]) begin
			if (d > 0)
				d = '0;
			if (d < -$signed({2'd0, long_ticks})) begin
				dwell[s] = '0;
				kind = EV_LONG;
				return 1'b1;
			end
			dwell[s] = d - 14'sd1;
			return 1'b0;
		end
		dwell[s] = '0;
		return 1'b0;
	endfunction

	task automatic clear_predictor();
		en_mask = '0;
		deb_ticks = DEBOUNCE_RESET;
		long_ticks = LONGPRESS_RESET;
		for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
			stable_lvl[s] = 1'b1;
			dwell[s] = '0;
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SLOT_ENABLE: begin
				for (int s = 0; s < SLOT_COUNT_DEF; s++)
					if (val[s] && !en_mask[s]) begin
						stable_lvl[s] = 1'b1;
						dwell[s] = '0;
					end
				en_mask = val;
			end
			REG_DEB_LIMIT: deb_ticks = val[DEBOUNCE_W-1:0];
			REG_LONG_LIMIT: long_ticks = val[LONGPRESS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// called right after a rising edge; leaves s_tvalid high for a following word
	task automatic send_word(input logic [SLOT_W-1:0] s, input logic lvl);
		button_event_t ev;
		bdl_event_t kind;
		if (src_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, lvl, s};
		do begin
			@(negedge clk);
		end while (!s_tready);
		if (en_mask[s])
			live_words++;
		if (debounce_predict(s, lvl, kind)) begin
			ev.slot = s;
			ev.kind = kind;
			event_q.push_back(ev);
		end
		@(posedge clk);
	endtask

	// block idle: no word offered, every event delivered, pipeline flushed
	task automatic settle();
		s_tvalid <= 1'b0;
		while (event_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		logic [SLOT_W-1:0] s;
		s = SLOT_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
		for (int i = 0; i < 16 && !en_mask[s]; i++)
			s = SLOT_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
		return s;
	endfunction

	// bounce, hold low (with stray words from random slots), bounce, release
	task automatic gesture(input logic [SLOT_W-1:0] s);
		int hold_n;
		repeat ($urandom_range(0, 3)) begin
			send_word(s, 1'b0);
			send_word(s, 1'b1);
		end
		hold_n = deb_ticks + 1 + $urandom_range(0, 2 * long_ticks + 6);
		repeat (hold_n) begin
			if ($urandom_range(0, 9) == 0)
				send_word(SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			send_word(s, 1'b0);
		end
		repeat ($urandom_range(0, 3)) begin
			send_word(s, 1'b1);
			send_word(s, 1'b0);
		end
		repeat (deb_ticks + 1 + $urandom_range(0, 3))
			send_word(s, 1'b1);
	endtask

	task automatic gesture_run(input int words);
		int target;
		target = live_words + words;
		while (live_words < target) begin
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 8))
					send_word(SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			else
				gesture(pick_slot());
		end
	endtask

	task automatic test_reset_state();
		send_word(4'd3, 1'b0);
		send_word(4'd12, 1'b1);
		settle();
		write_reg(REG_SLOT_ENABLE, 16'h0001);
		repeat (5) send_word(4'd0, 1'b0);
		repeat (5) send_word(4'd0, 1'b1);
		settle();
	endtask

	task automatic test_directed_cases();
		write_reg(REG_DEB_LIMIT, 16'd0);
		write_reg(REG_LONG_LIMIT, 16'd0);
		write_reg(REG_SLOT_ENABLE, 16'h8001);
		// press, long, release
		repeat (4) send_word(4'd0, 1'b0);
		repeat (2) send_word(4'd0, 1'b1);
		// agreeing high clears a pending count
		send_word(4'd15, 1'b0);
		send_word(4'd15, 1'b1);
		repeat (2) send_word(4'd15, 1'b0);
		// positive count cleared before counting down
		send_word(4'd15, 1'b1);
		repeat (2) send_word(4'd15, 1'b0);
		settle();
		// disabled while held: ignored, then re-enable restarts released
		write_reg(REG_SLOT_ENABLE, 16'h0001);
		send_word(4'd15, 1'b1);
		settle();
		write_reg(REG_SLOT_ENABLE, 16'h8001);
		send_word(4'd15, 1'b1);
		settle();
	endtask

	task automatic test_count_extremes();
		write_reg(REG_DEB_LIMIT, 16'd255);
		write_reg(REG_LONG_LIMIT, 16'd4095);
		write_reg(REG_SLOT_ENABLE, 16'h0080);
		repeat (257 + 40) send_word(4'd7, 1'b0);
		repeat (257) send_word(4'd7, 1'b1);
		settle();
	endtask

	task automatic random_setting(input int p);
		logic [DEBOUNCE_W-1:0]  deb;
		logic [LONGPRESS_W-1:0] lp;
		case (p)
			0: begin deb = '0; lp = '0; end
			1: begin deb = 8'd1; lp = 12'd3; end
			default: begin
				deb = 8'($urandom_range(0, 6));
				lp = 12'($urandom_range(0, 24));
			end
		endcase
		write_reg(REG_SLOT_ENABLE,
			16'($urandom() | $urandom()) | 16'(1 << $urandom_range(0, 15)));
		write_reg(REG_DEB_LIMIT, {8'($urandom_range(0, 255)), deb});
		write_reg(REG_LONG_LIMIT, {4'($urandom_range(0, 15)), lp});
	endtask

	task automatic test_random_gestures();
		for (int p = 0; p < 6; p++) begin
			random_setting(p);
			gesture_run(75);
			settle();
		end
	endtask

	task automatic test_output_backpressure();
		write_reg(REG_DEB_LIMIT, 16'd0);
		write_reg(REG_LONG_LIMIT, 16'd0);
		write_reg(REG_SLOT_ENABLE, 16'hFFFF);
		src_idle = 1'b0;
		@(negedge clk);
		hold_left = BP_HOLD_CYCLES;
		@(posedge clk);
		repeat (80) send_word(SLOT_W'($urandom_range(4, 5)), 1'b0);
		settle();
		src_idle = 1'b1;
	endtask

	task automatic test_full_rate();
		src_idle = 1'b0;
		rdy_idle = 1'b0;
		random_setting(2);
		gesture_run(140);
		settle();
	endtask

	// receiver: long hold-off on request, else random stall bursts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (rdy_gap > 0) begin
			m_tready <= 1'b0;
			rdy_gap = rdy_gap - 1;
		end else if (rdy_idle && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rdy_gap = $urandom_range(1, 10) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (event_q.size() == 0) begin
				report_mismatch($sformatf("unexpected event word %h", m_tdata));
			end else begin
				got_ev = event_q.pop_front();
				events_checked++;
				if (m_tdata[3:0] !== got_ev.slot)
					report_mismatch($sformatf("slot %0d, expected %0d",
						m_tdata[3:0], got_ev.slot));
				if (m_tdata[5:4] !== got_ev.kind)
					report_mismatch($sformatf("slot %0d kind %0d, expected %s",
						got_ev.slot, m_tdata[5:4], got_ev.kind.name()));
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		clear_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_cases();
		test_count_extremes();
		test_random_gestures();
		test_output_backpressure();
		test_full_rate();
		repeat (8) @(posedge clk);
		if (event_q.size() != 0)
			report_mismatch($sformatf("%0d expected events never arrived", event_q.size()));
		$display("covered: %0d samples on enabled slots, %0d events checked",
			live_words, events_checked);
		$display("debounce 0..255, long press thresholds up to 4095, slot enable changes, stalls");
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/bdl_pkg.sv
rtl/bdl_cfg.sv
rtl/bdl_slots.sv
rtl/button_debounce_longpress_top.sv
test/tb_button_debounce_longpress_top.sv
